// ===== sv/gbcs_pkg.sv =====
// Shared types and constants for the gyro bias calibrate and scale block.
// No dependencies; used by every module of the block via scoped names.
package gbcs_pkg;

    // Frame schedule: frames discarded, then frames averaged.
    localparam int SKIP_FRAMES = 64;
    localparam int AVG_FRAMES  = 64;     // must be a power of two
    localparam int AVG_SHIFT   = $clog2(AVG_FRAMES);

    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] SKIP_END = CNT_W'(SKIP_FRAMES);
    localparam logic [CNT_W-1:0] AVG_END  = CNT_W'(SKIP_FRAMES + AVG_FRAMES);
    localparam logic [CNT_W-1:0] CAL_DONE = CNT_W'(SKIP_FRAMES + AVG_FRAMES + 1);

    // Running gyro sum width: 16-bit samples times AVG_FRAMES.
    localparam int BIAS_W = 16 + AVG_SHIFT;
    localparam logic [BIAS_W-1:0] AVG_ROUND = BIAS_W'(AVG_FRAMES - 1);

    localparam int RAW_W  = 16;
    localparam int CORR_W = 17;
    localparam int SCL_W  = 16;
    localparam int OUT_W  = 24;

    // Configuration register indexes.
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_ACCEL_SCALE = 2'd0;
    localparam logic [IDX_W-1:0] REG_GYRO_SCALE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAGN_SCALE  = 2'd2;

    localparam logic [SCL_W-1:0] ACCEL_SCALE_RST = 16'd2048;
    localparam logic [SCL_W-1:0] GYRO_SCALE_RST  = 16'd17855;
    localparam logic [SCL_W-1:0] MAGN_SCALE_RST  = 16'd25420;

    typedef logic signed [RAW_W-1:0]  raw_t;
    typedef logic signed [CORR_W-1:0] corr_t;
    typedef logic signed [OUT_W-1:0]  out_t;
    typedef logic        [SCL_W-1:0]  scale_t;

    // Frame held in the input stage, all axes widened to the lane width.
    typedef struct packed {
        corr_t gyro_x;
        corr_t gyro_y;
        corr_t gyro_z;
        corr_t accel_x;
        corr_t accel_y;
        corr_t accel_z;
        corr_t magn_x;
        corr_t magn_y;
        corr_t magn_z;
    } frame_t;

    // Input stage status toward the top level.
    typedef struct packed {
        logic valid;       // a frame to be scaled is held
        logic calibrated;  // bias has been computed
    } cal_status_t;

endpackage

// ===== sv/gyro_bias_calibrate_and_scale_top.sv =====
// Top level of the gyro bias calibrate and scale block: config registers,
// handshake control and result register. Depends on gbcs_pkg, gbcs_calib,
// gbcs_scale_lane.

// Takes one nine-axis sensor frame per transaction and returns at most one
// scaled frame. The first 64 frames after reset are dropped, the next 64
// are summed per gyro axis with no result, and the frame after that yields
// the per-axis bias (sum / 64, toward zero) and goes out with its gyro axes
// uncorrected. Every later frame has the bias subtracted from its gyro axes.
// Each axis is output as (value * scale) >> 8 (floor), saturated to signed
// 24 bits; scales come from three config registers. The user must write them
// only while idle; the block does not enforce this. Throughput is one frame per
// clock unless m_ready stalls. The input transaction edge loads the input stage
// register (counter, bias add/subtract); the result register and m_valid then
// load through the nine parallel 17x16 multipliers when it is empty or taken.
// s_ready drops only while both the input stage and the result register hold a
// frame and m_ready is low. No clearing pass is needed after reset.
module gyro_bias_calibrate_and_scale_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write port
    input  logic                             cfg_we,
    input  logic [gbcs_pkg::IDX_W-1:0]       cfg_index,
    input  logic [gbcs_pkg::SCL_W-1:0]       cfg_wdata,
    // input frame channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_accel_x_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_accel_y_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_accel_z_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_gyro_x_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_gyro_y_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_gyro_z_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_magn_x_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_magn_y_raw,
    input  logic signed [gbcs_pkg::RAW_W-1:0] s_magn_z_raw,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_gyro_x_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_gyro_y_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_gyro_z_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_accel_x_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_accel_y_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_accel_z_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_magn_x_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_magn_y_out,
    output logic signed [gbcs_pkg::OUT_W-1:0] m_magn_z_out
);

    // ---------------------------------------------------------------
    // Config registers. Writes to an unused index fall through.
    // ---------------------------------------------------------------
    gbcs_pkg::scale_t accel_scale_reg;
    gbcs_pkg::scale_t gyro_scale_reg;
    gbcs_pkg::scale_t magn_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_scale_reg <= gbcs_pkg::ACCEL_SCALE_RST;
            gyro_scale_reg  <= gbcs_pkg::GYRO_SCALE_RST;
            magn_scale_reg  <= gbcs_pkg::MAGN_SCALE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                gbcs_pkg::REG_ACCEL_SCALE: accel_scale_reg <= cfg_wdata;
                gbcs_pkg::REG_GYRO_SCALE:  gyro_scale_reg  <= cfg_wdata;
                gbcs_pkg::REG_MAGN_SCALE:  magn_scale_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control. The result register advances when empty or taken;
    // the input stage takes a new transaction when empty or when its
    // frame moves to the result register in the same cycle. Frames
    // that give no result never occupy the input stage.
    // ---------------------------------------------------------------
    logic                  m_valid_reg;
    logic                  advance;
    logic                  accept;
    gbcs_pkg::frame_t      frame;
    gbcs_pkg::cal_status_t status;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !status.valid || advance;
    assign accept  = s_valid && s_ready;

    gbcs_calib u_calib (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .advance (advance),
        .accel_x (s_accel_x_raw),
        .accel_y (s_accel_y_raw),
        .accel_z (s_accel_z_raw),
        .gyro_x  (s_gyro_x_raw),
        .gyro_y  (s_gyro_y_raw),
        .gyro_z  (s_gyro_z_raw),
        .magn_x  (s_magn_x_raw),
        .magn_y  (s_magn_y_raw),
        .magn_z  (s_magn_z_raw),
        .frame   (frame),
        .status  (status)
    );

    // ---------------------------------------------------------------
    // Nine scaling lanes, one multiplier each.
    // ---------------------------------------------------------------
    gbcs_pkg::out_t gx_s, gy_s, gz_s, ax_s, ay_s, az_s, mx_s, my_s, mz_s;

    gbcs_scale_lane u_lane_gx (.value(frame.gyro_x),  .scale(gyro_scale_reg),  .result(gx_s));
    gbcs_scale_lane u_lane_gy (.value(frame.gyro_y),  .scale(gyro_scale_reg),  .result(gy_s));
    gbcs_scale_lane u_lane_gz (.value(frame.gyro_z),  .scale(gyro_scale_reg),  .result(gz_s));
    gbcs_scale_lane u_lane_ax (.value(frame.accel_x), .scale(accel_scale_reg), .result(ax_s));
    gbcs_scale_lane u_lane_ay (.value(frame.accel_y), .scale(accel_scale_reg), .result(ay_s));
    gbcs_scale_lane u_lane_az (.value(frame.accel_z), .scale(accel_scale_reg), .result(az_s));
    gbcs_scale_lane u_lane_mx (.value(frame.magn_x),  .scale(magn_scale_reg),  .result(mx_s));
    gbcs_scale_lane u_lane_my (.value(frame.magn_y),  .scale(magn_scale_reg),  .result(my_s));
    gbcs_scale_lane u_lane_mz (.value(frame.magn_z),  .scale(magn_scale_reg),  .result(mz_s));

    // ---------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------
    gbcs_pkg::out_t gx_reg, gy_reg, gz_reg, ax_reg, ay_reg, az_reg, mx_reg, my_reg, mz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= status.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && status.valid) begin
            gx_reg <= gx_s;
            gy_reg <= gy_s;
            gz_reg <= gz_s;
            ax_reg <= ax_s;
            ay_reg <= ay_s;
            az_reg <= az_s;
            mx_reg <= mx_s;
            my_reg <= my_s;
            mz_reg <= mz_s;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_gyro_x_out  = gx_reg;
    assign m_gyro_y_out  = gy_reg;
    assign m_gyro_z_out  = gz_reg;
    assign m_accel_x_out = ax_reg;
    assign m_accel_y_out = ay_reg;
    assign m_accel_z_out = az_reg;
    assign m_magn_x_out  = mx_reg;
    assign m_magn_y_out  = my_reg;
    assign m_magn_z_out  = mz_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // A frame in the input stage implies calibration has finished.
    a_stage_after_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        status.valid |-> status.calibrated)
        else $error("input stage holds a frame before calibration finished");

    // A result only appears when the input stage held a frame.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(status.valid))
        else $error("result appeared with no frame in the input stage");

    // A stalled result keeps the waiting input stage frame in place.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && status.valid) |=> status.valid)
        else $error("input stage frame lost while result stalled");

endmodule

// ===== sv/gbcs_scale_lane.sv =====
// One scaling lane: (value * scale) >> 8, floor rounding, saturated to 24 bits.
// Depends on gbcs_pkg.
module gbcs_scale_lane (
    input  gbcs_pkg::corr_t  value,
    input  gbcs_pkg::scale_t scale,
    output gbcs_pkg::out_t   result
);

    logic signed [gbcs_pkg::CORR_W+gbcs_pkg::SCL_W:0]   prod;
    logic signed [gbcs_pkg::CORR_W+gbcs_pkg::SCL_W-8:0] shifted;
    logic                                               ovf;

    always_comb begin
        prod    = value * $signed({1'b0, scale});
        shifted = prod[gbcs_pkg::CORR_W+gbcs_pkg::SCL_W:8];
        // overflow when the bits above the output sign are not all copies of it
        ovf = (shifted[gbcs_pkg::CORR_W+gbcs_pkg::SCL_W-8:gbcs_pkg::OUT_W-1] != '0) &&
              (shifted[gbcs_pkg::CORR_W+gbcs_pkg::SCL_W-8:gbcs_pkg::OUT_W-1] != '1);
        if (!ovf) begin
            result = shifted[gbcs_pkg::OUT_W-1:0];
        end else if (shifted[gbcs_pkg::CORR_W+gbcs_pkg::SCL_W-8]) begin
            result = {1'b1, {(gbcs_pkg::OUT_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(gbcs_pkg::OUT_W-1){1'b1}}};
        end
    end

endmodule

// ===== sv/gbcs_calib.sv =====
// Input stage: frame counter, gyro bias accumulation and bias subtraction.
// Depends on gbcs_pkg.
module gbcs_calib (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   advance,
    input  gbcs_pkg::raw_t         accel_x,
    input  gbcs_pkg::raw_t         accel_y,
    input  gbcs_pkg::raw_t         accel_z,
    input  gbcs_pkg::raw_t         gyro_x,
    input  gbcs_pkg::raw_t         gyro_y,
    input  gbcs_pkg::raw_t         gyro_z,
    input  gbcs_pkg::raw_t         magn_x,
    input  gbcs_pkg::raw_t         magn_y,
    input  gbcs_pkg::raw_t         magn_z,
    output gbcs_pkg::frame_t       frame,
    output gbcs_pkg::cal_status_t  status
);

    logic [gbcs_pkg::CNT_W-1:0]         count_reg, count_next;
    logic signed [gbcs_pkg::BIAS_W-1:0] bias_x_reg, bias_x_next;
    logic signed [gbcs_pkg::BIAS_W-1:0] bias_y_reg, bias_y_next;
    logic signed [gbcs_pkg::BIAS_W-1:0] bias_z_reg, bias_z_next;
    logic                               valid_reg, valid_next;
    gbcs_pkg::frame_t                   frame_reg, frame_next;
    logic                               emit;

    function automatic logic signed [gbcs_pkg::BIAS_W-1:0] sext_bias(gbcs_pkg::raw_t v);
        sext_bias = {{(gbcs_pkg::BIAS_W-gbcs_pkg::RAW_W){v[gbcs_pkg::RAW_W-1]}}, v};
    endfunction

    function automatic gbcs_pkg::corr_t sext_corr(gbcs_pkg::raw_t v);
        sext_corr = {v[gbcs_pkg::RAW_W-1], v};
    endfunction

    // sum / AVG_FRAMES, truncating toward zero
    function automatic logic signed [gbcs_pkg::BIAS_W-1:0] avg_div(
        logic signed [gbcs_pkg::BIAS_W-1:0] s
    );
        logic signed [gbcs_pkg::BIAS_W-1:0] r;
        r = s + (s[gbcs_pkg::BIAS_W-1] ? gbcs_pkg::AVG_ROUND : '0);
        avg_div = r >>> gbcs_pkg::AVG_SHIFT;
    endfunction

    always_comb begin
        count_next  = count_reg;
        bias_x_next = bias_x_reg;
        bias_y_next = bias_y_reg;
        bias_z_next = bias_z_reg;
        emit        = 1'b0;
        frame_next  = frame_reg;
        frame_next.accel_x = sext_corr(accel_x);
        frame_next.accel_y = sext_corr(accel_y);
        frame_next.accel_z = sext_corr(accel_z);
        frame_next.magn_x  = sext_corr(magn_x);
        frame_next.magn_y  = sext_corr(magn_y);
        frame_next.magn_z  = sext_corr(magn_z);
        frame_next.gyro_x  = sext_corr(gyro_x);
        frame_next.gyro_y  = sext_corr(gyro_y);
        frame_next.gyro_z  = sext_corr(gyro_z);
        if (accept) begin
            if (count_reg < gbcs_pkg::SKIP_END) begin
                count_next = count_reg + 1'b1;
            end else if (count_reg < gbcs_pkg::AVG_END) begin
                bias_x_next = bias_x_reg + sext_bias(gyro_x);
                bias_y_next = bias_y_reg + sext_bias(gyro_y);
                bias_z_next = bias_z_reg + sext_bias(gyro_z);
                count_next  = count_reg + 1'b1;
            end else if (count_reg == gbcs_pkg::AVG_END) begin
                // completing frame goes out uncorrected
                bias_x_next = avg_div(bias_x_reg);
                bias_y_next = avg_div(bias_y_reg);
                bias_z_next = avg_div(bias_z_reg);
                count_next  = count_reg + 1'b1;
                emit        = 1'b1;
            end else begin
                // bias fits 16 bits here, so 17-bit difference cannot wrap
                frame_next.gyro_x = sext_corr(gyro_x) - bias_x_reg[gbcs_pkg::CORR_W-1:0];
                frame_next.gyro_y = sext_corr(gyro_y) - bias_y_reg[gbcs_pkg::CORR_W-1:0];
                frame_next.gyro_z = sext_corr(gyro_z) - bias_z_reg[gbcs_pkg::CORR_W-1:0];
                emit = 1'b1;
            end
        end

        if (accept && emit) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            bias_x_reg <= '0;
            bias_y_reg <= '0;
            bias_z_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            count_reg  <= count_next;
            bias_x_reg <= bias_x_next;
            bias_y_reg <= bias_y_next;
            bias_z_reg <= bias_z_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            frame_reg <= frame_next;
        end
    end

    assign frame             = frame_reg;
    assign status.valid      = valid_reg;
    assign status.calibrated = (count_reg == gbcs_pkg::CAL_DONE);

endmodule

// ===== dv/tb_gyro_bias_calibrate_and_scale_top.sv =====
// Self-checking testbench for gyro_bias_calibrate_and_scale_top: directed and random
// sensor frames through both handshake channels, checked against a local predictor.
// Depends on gbcs_pkg and gyro_bias_calibrate_and_scale_top.
`timescale 1ns / 100ps

module tb_gyro_bias_calibrate_and_scale_top;

    // Timing and run-length knobs.
    localparam int LATENCY      = 1;          // input transaction edge to m_valid
    localparam int DRAIN_CYCLES = LATENCY + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;        // receiver back-pressure stretch
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 100;

    // Index that decodes to no register; writes to it must be dropped.
    localparam logic [gbcs_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam longint SAT_HI = (longint'(1) <<< (gbcs_pkg::OUT_W - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (gbcs_pkg::OUT_W - 1));

    // One input frame, grouped by sensor; index 0/1/2 is x/y/z.
    typedef struct {
        gbcs_pkg::raw_t accel[3];
        gbcs_pkg::raw_t gyro[3];
        gbcs_pkg::raw_t magn[3];
    } sensor_frame_t;

    // One result frame in port order: gyro xyz, accel xyz, magn xyz.
    typedef struct {
        gbcs_pkg::out_t axis[9];
    } scaled_frame_t;

    // ------------------------------------------------------------------
    // Scoreboard: tracks calibration state and gains, predicts each scaled
    // frame on input acceptance, compares results in order.
    // ------------------------------------------------------------------
    class imu_scoreboard;
        scaled_frame_t                      pending_scaled[$];
        int                                 errors;
        int                                 results_seen;
        logic [gbcs_pkg::CNT_W-1:0]         frames_seen;
        logic signed [gbcs_pkg::BIAS_W-1:0] gyro_bias[3];
        gbcs_pkg::scale_t                   accel_gain;
        gbcs_pkg::scale_t                   gyro_gain;
        gbcs_pkg::scale_t                   magn_gain;
        string axis_name[9] = '{"gyro_x_out", "gyro_y_out", "gyro_z_out",
                                "accel_x_out", "accel_y_out", "accel_z_out",
                                "magn_x_out", "magn_y_out", "magn_z_out"};

        function new();
            errors       = 0;
            results_seen = 0;
            frames_seen  = '0;
            foreach (gyro_bias[i]) gyro_bias[i] = '0;
            accel_gain = gbcs_pkg::ACCEL_SCALE_RST;
            gyro_gain  = gbcs_pkg::GYRO_SCALE_RST;
            magn_gain  = gbcs_pkg::MAGN_SCALE_RST;
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return pending_scaled.size();
        endfunction

        function void set_gain(input logic [gbcs_pkg::IDX_W-1:0] idx,
                               input gbcs_pkg::scale_t data);
            case (idx)
                gbcs_pkg::REG_ACCEL_SCALE: accel_gain = data;
                gbcs_pkg::REG_GYRO_SCALE:  gyro_gain  = data;
                gbcs_pkg::REG_MAGN_SCALE:  magn_gain  = data;
                default: ;
            endcase
        endfunction

        // (v * gain) >> 8, floor, clipped to the signed output range.
        function gbcs_pkg::out_t apply_gain(input logic signed [gbcs_pkg::BIAS_W:0] v,
                                            input gbcs_pkg::scale_t gain);
            longint prod;
            longint q;
            prod = longint'(v) * longint'(gain);
            q = prod >>> 8;
            if (q > SAT_HI) q = SAT_HI;
            if (q < SAT_LO) q = SAT_LO;
            return gbcs_pkg::out_t'(q);
        endfunction

        function void frame_accepted(input sensor_frame_t f);
            logic signed [gbcs_pkg::BIAS_W:0] rate[3];
            scaled_frame_t                    want;
            if (frames_seen < gbcs_pkg::SKIP_END) begin
                frames_seen++;
                return;
            end
            if (frames_seen < gbcs_pkg::AVG_END) begin
                foreach (gyro_bias[i]) gyro_bias[i] = gyro_bias[i] + f.gyro[i];
                frames_seen++;
                return;
            end
            if (frames_seen == gbcs_pkg::AVG_END) begin
                // Closing frame: sums become bias (toward zero), frame passes raw.
                foreach (gyro_bias[i]) begin
                    gyro_bias[i] = gyro_bias[i] / gbcs_pkg::AVG_FRAMES;
                    rate[i] = f.gyro[i];
                end
                frames_seen++;
            end else begin
                foreach (rate[i]) rate[i] = f.gyro[i] - gyro_bias[i];
            end
            for (int i = 0; i < 3; i++) begin
                want.axis[i]     = apply_gain(rate[i], gyro_gain);
                want.axis[i + 3] = apply_gain(f.accel[i], accel_gain);
                want.axis[i + 6] = apply_gain(f.magn[i], magn_gain);
            end
            pending_scaled.push_back(want);
        endfunction

        task check_scaled(input scaled_frame_t got);
            scaled_frame_t want;
            if (pending_scaled.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                results_seen++;
                return;
            end
            want = pending_scaled.pop_front();
            foreach (want.axis[i])
                if (got.axis[i] !== want.axis[i])
                    report($sformatf("result %0d %s: got %0d expected %0d", results_seen,
                                     axis_name[i], got.axis[i], want.axis[i]));
            results_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [gbcs_pkg::IDX_W-1:0] cfg_index = '0;
    logic [gbcs_pkg::SCL_W-1:0] cfg_wdata = '0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    gbcs_pkg::raw_t s_accel_x_raw = '0, s_accel_y_raw = '0, s_accel_z_raw = '0;
    gbcs_pkg::raw_t s_gyro_x_raw  = '0, s_gyro_y_raw  = '0, s_gyro_z_raw  = '0;
    gbcs_pkg::raw_t s_magn_x_raw  = '0, s_magn_y_raw  = '0, s_magn_z_raw  = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    gbcs_pkg::out_t m_gyro_x_out, m_gyro_y_out, m_gyro_z_out;
    gbcs_pkg::out_t m_accel_x_out, m_accel_y_out, m_accel_z_out;
    gbcs_pkg::out_t m_magn_x_out, m_magn_y_out, m_magn_z_out;

    imu_scoreboard sb = new();

    logic long_hold_req = 1'b0;    // set by stimulus, served by the receiver
    int   burst_left    = 0;
    int   cycle_count   = 0;

    gyro_bias_calibrate_and_scale_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_accel_x_raw (s_accel_x_raw),
        .s_accel_y_raw (s_accel_y_raw),
        .s_accel_z_raw (s_accel_z_raw),
        .s_gyro_x_raw  (s_gyro_x_raw),
        .s_gyro_y_raw  (s_gyro_y_raw),
        .s_gyro_z_raw  (s_gyro_z_raw),
        .s_magn_x_raw  (s_magn_x_raw),
        .s_magn_y_raw  (s_magn_y_raw),
        .s_magn_z_raw  (s_magn_z_raw),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gyro_x_out  (m_gyro_x_out),
        .m_gyro_y_out  (m_gyro_y_out),
        .m_gyro_z_out  (m_gyro_z_out),
        .m_accel_x_out (m_accel_x_out),
        .m_accel_y_out (m_accel_y_out),
        .m_accel_z_out (m_accel_z_out),
        .m_magn_x_out  (m_magn_x_out),
        .m_magn_y_out  (m_magn_y_out),
        .m_magn_z_out  (m_magn_z_out)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_gyro_bias_calibrate_and_scale_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Axis value biased toward the corners: rails, zero, -1, near zero.
    function automatic gbcs_pkg::raw_t random_axis();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            4, 5:    return gbcs_pkg::raw_t'(int'($urandom_range(0, 128)) - 64);
            default: return gbcs_pkg::raw_t'($urandom);
        endcase
    endfunction

    function automatic sensor_frame_t random_frame();
        sensor_frame_t f;
        for (int i = 0; i < 3; i++) begin
            f.accel[i] = random_axis();
            f.gyro[i]  = random_axis();
            f.magn[i]  = random_axis();
        end
        return f;
    endfunction

    function automatic sensor_frame_t flat_frame(input gbcs_pkg::raw_t v);
        sensor_frame_t f;
        for (int i = 0; i < 3; i++) begin
            f.accel[i] = v;
            f.gyro[i]  = v;
            f.magn[i]  = v;
        end
        return f;
    endfunction

    function automatic gbcs_pkg::scale_t pick_gain(input gbcs_pkg::scale_t rst_val);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return rst_val;
            3:       return gbcs_pkg::scale_t'(1);
            default: return gbcs_pkg::scale_t'($urandom);
        endcase
    endfunction

    // One input transaction. The sender runs in bursts; between bursts valid
    // drops for a random gap (sometimes none, so long back-to-back runs occur).
    task automatic send_frame(input sensor_frame_t f);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 64);
        end
        burst_left--;
        s_accel_x_raw <= f.accel[0];
        s_accel_y_raw <= f.accel[1];
        s_accel_z_raw <= f.accel[2];
        s_gyro_x_raw  <= f.gyro[0];
        s_gyro_y_raw  <= f.gyro[1];
        s_gyro_z_raw  <= f.gyro[2];
        s_magn_x_raw  <= f.magn[0];
        s_magn_y_raw  <= f.magn[1];
        s_magn_z_raw  <= f.magn[2];
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.frame_accepted(f);
    endtask

    // Stop offering, let every expected result drain, then let the pipeline
    // empty of frames that produce nothing.
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gbcs_pkg::IDX_W-1:0] idx,
                             input gbcs_pkg::scale_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.set_gain(idx, data);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_gains(input gbcs_pkg::scale_t accel, input gbcs_pkg::scale_t gyro,
                               input gbcs_pkg::scale_t magn);
        write_reg(gbcs_pkg::REG_ACCEL_SCALE, accel);
        write_reg(gbcs_pkg::REG_GYRO_SCALE, gyro);
        write_reg(gbcs_pkg::REG_MAGN_SCALE, magn);
    endtask

    // ------------------------------------------------------------------
    // Receiver: m_ready follows a random pattern that is picked anew for each
    // span. On request it holds m_ready low for the LONG_HOLD stretch so the block
    // fills up and pushes back on s_ready while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int span;
        int tick;
        tick = 0;
        wait (aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                if (long_hold_req) begin
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    long_hold_req = 1'b0;
                end else begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        2:       m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= tick[0];
                    endcase
                end
            end
        end
    end

    // Result monitor: sample at the edge, compare with the oldest prediction.
    always @(posedge aclk) begin
        scaled_frame_t got;
        if (aresetn && m_valid && m_ready) begin
            got.axis[0] = m_gyro_x_out;
            got.axis[1] = m_gyro_y_out;
            got.axis[2] = m_gyro_z_out;
            got.axis[3] = m_accel_x_out;
            got.axis[4] = m_accel_y_out;
            got.axis[5] = m_accel_z_out;
            got.axis[6] = m_magn_x_out;
            got.axis[7] = m_magn_y_out;
            got.axis[8] = m_magn_z_out;
            sb.check_scaled(got);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        sensor_frame_t f;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Calibration runs once per reset, with the reset gains left in place.
        // Skipped frames: arbitrary content, all of it must be dropped.
        repeat (gbcs_pkg::SKIP_FRAMES) send_frame(random_frame());

        // Averaged frames: gyro x pinned near the negative rail, y near the
        // positive rail, z small and mostly negative. That gives large biases
        // of both signs (so later frames can overflow 16 bits) and sums that
        // are not multiples of the frame count (truncation toward zero).
        repeat (gbcs_pkg::AVG_FRAMES) begin
            f = random_frame();
            f.gyro[0] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh8001;
            f.gyro[1] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh7FFE;
            f.gyro[2] = gbcs_pkg::raw_t'(int'($urandom_range(0, 120)) - 100);
            send_frame(f);
        end

        // Closing frame: bias latched, this frame goes out uncorrected at the
        // reset gains.
        f.gyro  = '{16'sh7FFF, 16'sh8000, 16'shFFFF};
        f.accel = '{16'sh7FFF, 16'sh8000, 16'sh0001};
        f.magn  = '{16'sh8000, 16'sh7FFF, 16'sh0000};
        send_frame(f);
        settle();

        // Full-scale gains: rails on every axis, corrected gyro overflows and
        // must clip at both ends of the output range.
        write_gains('1, '1, '1);
        send_frame(flat_frame(16'sh7FFF));
        send_frame(flat_frame(16'sh8000));
        send_frame(flat_frame(16'sh0000));
        send_frame(flat_frame(16'shFFFF));
        send_frame(flat_frame(16'sh5555));
        send_frame(flat_frame(16'shAAAA));
        settle();

        // Zero gains, plus a write to an unmapped index that must not land.
        write_gains('0, '0, '0);
        write_reg(REG_UNMAPPED, '1);
        send_frame(flat_frame(16'sh7FFF));
        send_frame(flat_frame(16'sh8000));
        settle();

        // Unit gain: floor rounding of small negatives (-1 stays -1).
        write_gains(gbcs_pkg::scale_t'(1), gbcs_pkg::scale_t'(1), gbcs_pkg::scale_t'(1));
        send_frame(flat_frame(16'sh8000));
        send_frame(flat_frame(16'sh7FFF));
        send_frame(flat_frame(16'shFFFF));
        settle();

        // Random phases, each with its own gain set. Two of them start with a
        // long receiver hold-off.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_gains(pick_gain(gbcs_pkg::ACCEL_SCALE_RST),
                        pick_gain(gbcs_pkg::GYRO_SCALE_RST),
                        pick_gain(gbcs_pkg::MAGN_SCALE_RST));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNMAPPED, gbcs_pkg::scale_t'($urandom));
            if (ph == 2 || ph == 6) long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_frame(random_frame());
            settle();
        end

        if (sb.errors == 0) begin
            $display("tb_gyro_bias_calibrate_and_scale_top OK");
        end else begin
            $display("tb_gyro_bias_calibrate_and_scale_top NOT OK");
        end
        $finish;
    end

endmodule
